// File: sv/afrc_pkg.sv
// shared constants, types and crc helper for the addressed frame receiver
package afrc_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'h5E;
  localparam logic [7:0]  BCAST_ADDR = 8'hFF;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_FINAL  = 16'h0001;
  localparam logic [7:0]  BYPASS_LO  = 8'hAA;
  localparam logic [7:0]  BYPASS_HI  = 8'hBB;
  localparam logic [7:0]  ERR_B3     = 8'hFF;
  localparam logic [7:0]  ERR_B4     = 8'h07;

  // data bytes after the header; the last one arrives live, the rest sit in cells
  localparam int FRAME_TAIL = 7;
  localparam int NUM_CELLS  = FRAME_TAIL - 1;

  // byte positions inside the tail (count of tail bytes taken before this one)
  localparam logic [2:0] POS_CRC_FIRST = 3'd2;
  localparam logic [2:0] POS_CRC_LAST  = 3'd4;
  localparam logic [2:0] POS_LAST      = 3'(FRAME_TAIL - 1);

  localparam logic [1:0] ACT_DELIVER = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_ERROR   = 2'd2;

  // control handed to the crc cell
  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctl_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = c_in;
    for (int j = 0; j < 8; j++) begin
      fb = c[0] ^ d[j];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/afrc_byte_cell.sv
// one byte cell of the receive shift chain
module afrc_byte_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  output logic [7:0] q
);

  // take the neighbor's byte on every accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= din;
    end
  end

endmodule

// File: sv/afrc_crc_cell.sv
// crc accumulator cell, one byte per beat
module afrc_crc_cell (
  input  logic               clk,
  input  afrc_pkg::crc_ctl_t ctl,
  input  logic [7:0]         din,
  output logic [15:0]        crc
);

  // preset at the header, fold in a byte when told
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      crc <= afrc_pkg::CRC_INIT;
    end else if (ctl.update) begin
      crc <= afrc_pkg::crc_byte(crc, din);
    end
  end

endmodule

// File: sv/addressed_frame_receiver_crc_check_top.sv
// top level of the addressed frame receiver with crc check
//
// Usage: received bytes enter on the rx channel (rx_valid / rx_ready / rx_byte),
// one beat per cycle. While idle every byte other than the header 0x5E is
// dropped. The header and the next seven bytes form a frame; the beat that
// carries the eighth byte produces one result beat on the out channel
// (out_valid / out_ready / action, byte0..byte7). Bytes shift through a chain
// of six byte cells while a crc cell folds in bytes 3 to 5 as they pass; the
// result is registered and shown in the cycle after the last byte is accepted.
// Throughput is one byte per cycle. node_address must be written through
// cfg_we / cfg_wdata only while the block is idle; the block does not enforce
// this. Reset (rst, synchronous) clears node_address, the frame tracking and
// the output valid. When the receiver stalls, the result waits in the output
// register and bytes keep being accepted; only the beat that would complete the
// next frame is held off (rx_ready low) until the waiting result is taken.
module addressed_frame_receiver_crc_check_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] action,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [7:0] byte3,
  output logic [7:0] byte4,
  output logic [7:0] byte5,
  output logic [7:0] byte6,
  output logic [7:0] byte7
);

  logic [7:0]  node_address;
  logic        in_frame;
  logic [2:0]  pos;
  logic        rx_fire;
  logic        last_beat;
  logic [7:0]  cell_q [afrc_pkg::NUM_CELLS];
  logic [15:0] crc;
  logic [15:0] crc_fin;
  afrc_pkg::crc_ctl_t crc_ctl;
  logic        addr_hit;
  logic        crc_ok;
  logic        bypass;
  logic [1:0]  act_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 8'h00;
    end else if (cfg_we) begin
      node_address <= cfg_wdata;
    end
  end

  // handshake: only the completing beat needs a free output slot
  assign last_beat = in_frame && (pos == afrc_pkg::POS_LAST);
  assign rx_ready  = !(last_beat && out_valid && !out_ready);
  assign rx_fire   = rx_valid && rx_ready;

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= 3'd0;
    end else if (rx_fire) begin
      if (!in_frame) begin
        if (rx_byte == afrc_pkg::HDR_BYTE) begin
          in_frame <= 1'b1;
          pos      <= 3'd0;
        end
      end else if (last_beat) begin
        in_frame <= 1'b0;
        pos      <= 3'd0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // byte chain: cell 0 takes the live byte, each cell hands on to the next
  for (genvar k = 0; k < afrc_pkg::NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      afrc_byte_cell u_cell (
        .clk      (clk),
        .shift_en (rx_fire),
        .din      (rx_byte),
        .q        (cell_q[k])
      );
    end else begin : g_body
      afrc_byte_cell u_cell (
        .clk      (clk),
        .shift_en (rx_fire),
        .din      (cell_q[k-1]),
        .q        (cell_q[k])
      );
    end
  end

  // crc cell control
  always_comb begin
    crc_ctl.clear  = rx_fire && !in_frame;
    crc_ctl.update = rx_fire && in_frame &&
                     (pos >= afrc_pkg::POS_CRC_FIRST) && (pos <= afrc_pkg::POS_CRC_LAST);
  end

  afrc_crc_cell u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .din (rx_byte),
    .crc (crc)
  );

  // decision on the completing beat: cell 5 is byte 1, cell 0 is byte 6
  assign crc_fin  = crc + afrc_pkg::CRC_FINAL;
  assign addr_hit = (cell_q[5] == node_address) || (cell_q[5] == afrc_pkg::BCAST_ADDR);
  assign crc_ok   = (cell_q[0] == crc_fin[7:0]) && (rx_byte == crc_fin[15:8]);
  assign bypass   = (cell_q[0] == afrc_pkg::BYPASS_LO) && (rx_byte == afrc_pkg::BYPASS_HI);

  always_comb begin
    if (!addr_hit) begin
      act_next = afrc_pkg::ACT_FORWARD;
    end else if (crc_ok || bypass) begin
      act_next = afrc_pkg::ACT_DELIVER;
    end else begin
      act_next = afrc_pkg::ACT_ERROR;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_fire && last_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (rx_fire && last_beat) begin
      action <= act_next;
      byte0  <= afrc_pkg::HDR_BYTE;
      byte1  <= cell_q[5];
      byte2  <= cell_q[4];
      byte3  <= (act_next == afrc_pkg::ACT_ERROR) ? afrc_pkg::ERR_B3 : cell_q[3];
      byte4  <= (act_next == afrc_pkg::ACT_ERROR) ? afrc_pkg::ERR_B4 : cell_q[2];
      byte5  <= cell_q[1];
      byte6  <= cell_q[0];
      byte7  <= rx_byte;
    end
  end

  // position stays at zero outside a frame
  assert property (@(posedge clk) disable iff (rst) !in_frame |-> pos == 3'd0)
    else $error("byte position nonzero while idle");

  // a completing beat always leaves a result behind
  assert property (@(posedge clk) disable iff (rst) (rx_fire && last_beat) |=> out_valid)
    else $error("completed frame produced no result");

  // a stalled result is never overwritten by the next frame
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(rx_fire && last_beat))
    else $error("result overwritten while stalled");

  // a shown result never carries an undefined action code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (action == afrc_pkg::ACT_DELIVER || action == afrc_pkg::ACT_FORWARD ||
                   action == afrc_pkg::ACT_ERROR))
    else $error("undefined action code");

endmodule

// File: sim/tb_addressed_frame_receiver_crc_check_top.sv
// testbench for the addressed frame receiver: directed and random frames against a scoreboard
`timescale 1ns / 1ps

module tb_addressed_frame_receiver_crc_check_top;

  localparam int PHASE_BYTES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 8;

  // one result beat: action plus the eight frame bytes
  typedef struct {
    logic [1:0] action;
    logic [7:0] fbyte [8];
  } frame_result_t;

  // frame tracker, crc predictor and store of expected result beats
  class frame_scoreboard;
    logic [7:0]    node_addr;
    bit            in_frame;
    int            tail_count;
    logic [7:0]    tail [afrc_pkg::FRAME_TAIL];
    frame_result_t pending_q [$];
    int            errors;

    function new();
      node_addr  = 8'h00;
      in_frame   = 1'b0;
      tail_count = 0;
      errors     = 0;
    endfunction

    // reflected crc over frame bytes 3..5, lsb first, plus one at the end
    function logic [15:0] frame_crc(logic [7:0] d3, logic [7:0] d4, logic [7:0] d5);
      logic [15:0] c;
      logic [23:0] bits;
      c    = afrc_pkg::CRC_INIT;
      bits = {d5, d4, d3};
      for (int i = 0; i < 24; i++) begin
        if (c[0] ^ bits[i]) begin
          c = (c >> 1) ^ afrc_pkg::CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c + afrc_pkg::CRC_FINAL;
    endfunction

    // accepted rx beat: track the frame and queue a result when it completes
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      logic [15:0]   crc;
      if (!in_frame) begin
        if (b == afrc_pkg::HDR_BYTE) begin
          in_frame   = 1'b1;
          tail_count = 0;
        end
        return;
      end
      tail[tail_count] = b;
      if (tail_count < afrc_pkg::FRAME_TAIL - 1) begin
        tail_count++;
        return;
      end
      in_frame   = 1'b0;
      tail_count = 0;
      r.fbyte[0] = afrc_pkg::HDR_BYTE;
      for (int k = 0; k < afrc_pkg::FRAME_TAIL; k++) begin
        r.fbyte[k + 1] = tail[k];
      end
      if (r.fbyte[1] != node_addr && r.fbyte[1] != afrc_pkg::BCAST_ADDR) begin
        r.action = afrc_pkg::ACT_FORWARD;
      end else begin
        crc = frame_crc(r.fbyte[3], r.fbyte[4], r.fbyte[5]);
        if ({r.fbyte[7], r.fbyte[6]} == crc ||
            (r.fbyte[6] == afrc_pkg::BYPASS_LO && r.fbyte[7] == afrc_pkg::BYPASS_HI)) begin
          r.action = afrc_pkg::ACT_DELIVER;
        end else begin
          r.action   = afrc_pkg::ACT_ERROR;
          r.fbyte[3] = afrc_pkg::ERR_B3;
          r.fbyte[4] = afrc_pkg::ERR_B4;
        end
      end
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // accepted result beat against the oldest expectation
    task check_result(frame_result_t got);
      frame_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result beat, action %0d byte1 %02h",
                         got.action, got.fbyte[1]));
        return;
      end
      want = pending_q.pop_front();
      if (got.action !== want.action) begin
        report($sformatf("action got %0d want %0d", got.action, want.action));
      end
      for (int k = 0; k < 8; k++) begin
        if (got.fbyte[k] !== want.fbyte[k]) begin
          report($sformatf("byte%0d got %02h want %02h", k, got.fbyte[k], want.fbyte[k]));
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       rx_valid;
  logic       rx_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] action;
  logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;

  frame_scoreboard sb;
  int              cycle_count;
  int              burst_left;
  bit              hold_req;

  addressed_frame_receiver_crc_check_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .byte0     (byte0),
    .byte1     (byte1),
    .byte2     (byte2),
    .byte3     (byte3),
    .byte4     (byte4),
    .byte5     (byte5),
    .byte6     (byte6),
    .byte7     (byte7)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_addressed_frame_receiver_crc_check_top: done, errors");
      $finish;
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    frame_result_t got;
    if (!rst) begin
      if (rx_valid && rx_ready) begin
        sb.note_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        got.action   = action;
        got.fbyte[0] = byte0;
        got.fbyte[1] = byte1;
        got.fbyte[2] = byte2;
        got.fbyte[3] = byte3;
        got.fbyte[4] = byte4;
        got.fbyte[5] = byte5;
        got.fbyte[6] = byte6;
        got.fbyte[7] = byte7;
        sb.check_result(got);
      end
    end
  end

  // receiver: stall pattern in random windows, plus a long hold-off on request
  initial begin
    int mode;
    int left;
    int hold_left;
    out_ready = 1'b0;
    mode      = 0;
    left      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (left % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // one rx beat, with a random gap before each new burst
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        rx_valid <= 1'b0;
        rx_byte  <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
  endtask

  task automatic send_frame(logic [7:0] addr, logic [7:0] d2, logic [7:0] d3,
                            logic [7:0] d4, logic [7:0] d5, logic [7:0] c_lo,
                            logic [7:0] c_hi);
    send_byte(afrc_pkg::HDR_BYTE);
    send_byte(addr);
    send_byte(d2);
    send_byte(d3);
    send_byte(d4);
    send_byte(d5);
    send_byte(c_lo);
    send_byte(c_hi);
  endtask

  // data byte biased toward the header value and the extremes
  function automatic logic [7:0] rand_data();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return afrc_pkg::HDR_BYTE;
    if (pick == 2) return 8'h00;
    if (pick == 3) return 8'hFF;
    return 8'($urandom);
  endfunction

  // well-formed frame with random content; tail is good crc, bypass, near miss or noise
  task automatic random_frame();
    logic [7:0]  addr, d2, d3, d4, d5, c_lo, c_hi;
    logic [15:0] crc;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) addr = sb.node_addr;
    else if (pick < 6) addr = afrc_pkg::BCAST_ADDR;
    else addr = rand_data();
    d2   = rand_data();
    d3   = rand_data();
    d4   = rand_data();
    d5   = rand_data();
    crc  = sb.frame_crc(d3, d4, d5);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      {c_hi, c_lo} = crc;
    end else if (pick < 6) begin
      c_lo = afrc_pkg::BYPASS_LO;
      c_hi = afrc_pkg::BYPASS_HI;
    end else if (pick < 8) begin
      {c_hi, c_lo} = crc ^ (16'h0001 << $urandom_range(0, 15));
    end else begin
      c_lo = rand_data();
      c_hi = rand_data();
    end
    send_frame(addr, d2, d3, d4, d5, c_lo, c_hi);
  endtask

  // stop offering beats and wait until every expected result has come
  task automatic wait_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // node address write, only while idle
  task automatic write_node(logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.node_addr = v;
  endtask

  // random phase: mostly whole frames, some idle noise between them
  task automatic run_phase(logic [7:0] node, bit long_hold);
    int         sent;
    logic [7:0] nb;
    write_node(node);
    if (long_hold) hold_req = 1'b1;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          nb = 8'($urandom);
          if (nb == afrc_pkg::HDR_BYTE) nb = 8'h00;
          send_byte(nb);
        end
      end else begin
        random_frame();
        sent += 8;
      end
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    logic [15:0] crc;
    sb         = new();
    burst_left = 0;
    hold_req   = 1'b0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 8'h00;
    rx_valid   = 1'b0;
    rx_byte    = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle bytes dropped, header value as data, every action
    write_node(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    crc = sb.frame_crc(8'h00, 8'hFF, afrc_pkg::HDR_BYTE);
    send_frame(8'h00, afrc_pkg::HDR_BYTE, 8'h00, 8'hFF, afrc_pkg::HDR_BYTE,
               crc[7:0], crc[15:8]);
    send_frame(afrc_pkg::BCAST_ADDR, 8'hFF, 8'h12, 8'h34, 8'h56,
               afrc_pkg::BYPASS_LO, afrc_pkg::BYPASS_HI);
    send_frame(8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    crc = sb.frame_crc(8'h80, 8'h01, 8'h7F);
    send_frame(8'h00, 8'h7F, 8'h80, 8'h01, 8'h7F, crc[7:0] ^ 8'h01, crc[15:8]);
    wait_drained();

    // random phases over several node addresses, extremes included
    run_phase(8'h00, 1'b0);
    run_phase(8'hFF, 1'b1);
    run_phase(8'($urandom), 1'b0);
    run_phase(afrc_pkg::HDR_BYTE, 1'b0);
    run_phase(8'($urandom), 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      sb.report($sformatf("%0d expected results never came", sb.pending_q.size()));
    end
    if (sb.errors == 0) begin
      $display("tb_addressed_frame_receiver_crc_check_top: done, clean");
    end else begin
      $display("tb_addressed_frame_receiver_crc_check_top: done, errors");
    end
    $finish;
  end

endmodule
